FILE: rtl/dll_pkg.sv
// shared types and constants for the data literal lexer
// result word layout, result kinds, error codes and result queue size
// no dependencies
package dll_pkg;

    // result kinds
    localparam logic [2:0] KIND_PUSH  = 3'd0;
    localparam logic [2:0] KIND_POP   = 3'd1;
    localparam logic [2:0] KIND_VALUE = 3'd2;
    localparam logic [2:0] KIND_FRAC  = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // error codes
    localparam logic ERR_CHAR   = 1'b0;
    localparam logic ERR_ESCAPE = 1'b1;

    // field widths
    localparam int RUNE_W  = 21;
    localparam int VALUE_W = 64;
    localparam int FRAC_W  = 8;

    // result queue entries, a power of two
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // one result word
    typedef struct packed {
        logic [2:0]         kind;
        logic [VALUE_W-1:0] value;
        logic [FRAC_W-1:0]  frac;
        logic               err;
        logic               sat;
        logic               last;
    } t_result;

    // up to two results caused by one rune
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_pair;

    // build a result word with last cleared
    function automatic t_result mk_res(input logic [2:0] kind,
                                       input logic [VALUE_W-1:0] value,
                                       input logic [FRAC_W-1:0] frac,
                                       input logic err,
                                       input logic sat);
        t_result res;
        res.kind  = kind;
        res.value = value;
        res.frac  = frac;
        res.err   = err;
        res.sat   = sat;
        res.last  = 1'b0;
        return res;
    endfunction

endpackage

FILE: rtl/dll_core.sv
// lexer state and per-rune decode: each rune is handled in the cycle it is accepted
// produces up to two results per accepted rune for the result queue
// depends on dll_pkg
module dll_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [dll_pkg::RUNE_W-1:0]  i_rune,
    input  logic                        i_eoi,
    output dll_pkg::t_pair              o_pair
);

    typedef enum logic [10:0] {
        M_NORMAL  = 11'b000_0000_0001,
        M_COMMENT = 11'b000_0000_0010,
        M_IDENT   = 11'b000_0000_0100,
        M_ZERO    = 11'b000_0000_1000,
        M_BIN     = 11'b000_0001_0000,
        M_OCT     = 11'b000_0010_0000,
        M_DEC     = 11'b000_0100_0000,
        M_HEX     = 11'b000_1000_0000,
        M_FRAC    = 11'b001_0000_0000,
        M_STRING  = 11'b010_0000_0000,
        M_ESCAPE  = 11'b100_0000_0000
    } t_mode;

    // ascii codes
    localparam logic [6:0] CH_TAB    = 7'h09;
    localparam logic [6:0] CH_CR     = 7'h0D;
    localparam logic [6:0] CH_NL     = 7'h0A;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_HASH   = 7'h23;
    localparam logic [6:0] CH_DOT    = 7'h2E;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_NINE   = 7'h39;
    localparam logic [6:0] CH_UP_A   = 7'h41;
    localparam logic [6:0] CH_UP_Z   = 7'h5A;
    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_USCORE = 7'h5F;
    localparam logic [6:0] CH_LO_A   = 7'h61;
    localparam logic [6:0] CH_LO_B   = 7'h62;
    localparam logic [6:0] CH_LO_E   = 7'h65;
    localparam logic [6:0] CH_LO_F   = 7'h66;
    localparam logic [6:0] CH_LO_N   = 7'h6E;
    localparam logic [6:0] CH_LO_O   = 7'h6F;
    localparam logic [6:0] CH_LO_R   = 7'h72;
    localparam logic [6:0] CH_LO_T   = 7'h74;
    localparam logic [6:0] CH_LO_V   = 7'h76;
    localparam logic [6:0] CH_LO_X   = 7'h78;
    localparam logic [6:0] CH_LO_Z   = 7'h7A;
    localparam logic [6:0] CH_LBRACE = 7'h7B;
    localparam logic [6:0] CH_RBRACE = 7'h7D;
    localparam logic [5:0] NO_DIGIT  = 6'd63;

    localparam int VW = dll_pkg::VALUE_W;
    localparam int FW = dll_pkg::FRAC_W;

    t_mode            r_mode, n_mode;
    logic [VW-1:0]    r_acc, n_acc;
    logic             r_ovf, n_ovf;
    logic [FW-1:0]    r_cnt, n_cnt;
    logic             r_halt, n_halt;

    // rune classes
    logic       is_ascii;
    logic [6:0] ch;
    logic       is_space, is_digit, is_upper, is_lower, is_letter;
    logic [5:0] d_val;
    logic       esc_ok;
    logic [6:0] esc_code;

    assign is_ascii  = (i_rune[dll_pkg::RUNE_W-1:7] == '0);
    assign ch        = i_rune[6:0];
    assign is_space  = is_ascii && (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR));
    assign is_digit  = is_ascii && ch >= CH_ZERO && ch <= CH_NINE;
    assign is_upper  = is_ascii && ch >= CH_UP_A && ch <= CH_UP_Z;
    assign is_lower  = is_ascii && ch >= CH_LO_A && ch <= CH_LO_Z;
    assign is_letter = is_upper || is_lower;

    // digit value in any base up to 36
    always_comb begin
        d_val = NO_DIGIT;
        if (is_digit) begin
            d_val = 6'(ch - CH_ZERO);
        end else if (is_lower) begin
            d_val = 6'(ch - CH_LO_A) + 6'd10;
        end else if (is_upper) begin
            d_val = 6'(ch - CH_UP_A) + 6'd10;
        end
    end

    // escape letters
    always_comb begin
        esc_ok   = is_ascii;
        esc_code = 7'd0;
        case (ch)
            CH_LO_A:   esc_code = 7'd7;
            CH_LO_B:   esc_code = 7'd8;
            CH_LO_E:   esc_code = 7'd27;
            CH_LO_F:   esc_code = 7'd12;
            CH_LO_N:   esc_code = 7'd10;
            CH_LO_R:   esc_code = 7'd13;
            CH_LO_T:   esc_code = 7'd9;
            CH_LO_V:   esc_code = 7'd11;
            CH_BSLASH: esc_code = CH_BSLASH;
            CH_QUOTE:  esc_code = CH_QUOTE;
            default:   esc_ok   = 1'b0;
        endcase
    end

    // rune taken in normal mode, independent of state
    t_mode            nrm_mode;
    logic [VW-1:0]    nrm_acc;
    logic             nrm_emit;
    logic             nrm_halt;
    dll_pkg::t_result nrm_res;

    always_comb begin
        nrm_mode = M_NORMAL;
        nrm_acc  = '0;
        nrm_emit = 1'b0;
        nrm_halt = 1'b0;
        nrm_res  = dll_pkg::mk_res(dll_pkg::KIND_PUSH, '0, '0, 1'b0, 1'b0);
        if (is_space) begin
            nrm_mode = M_NORMAL;
        end else if (is_ascii && ch == CH_ZERO) begin
            nrm_mode = M_ZERO;
        end else if (is_digit) begin
            nrm_mode = M_DEC;
            nrm_acc  = VW'(d_val);
        end else if (is_ascii && ch == CH_QUOTE) begin
            nrm_mode = M_STRING;
        end else if (is_letter) begin
            nrm_mode = M_IDENT;
        end else if (is_ascii && ch == CH_HASH) begin
            nrm_mode = M_COMMENT;
        end else if (is_ascii && ch == CH_LBRACE) begin
            nrm_emit = 1'b1;
        end else if (is_ascii && ch == CH_RBRACE) begin
            nrm_emit = 1'b1;
            nrm_res  = dll_pkg::mk_res(dll_pkg::KIND_POP, '0, '0, 1'b0, 1'b0);
        end else begin
            nrm_emit = 1'b1;
            nrm_halt = 1'b1;
            nrm_res  = dll_pkg::mk_res(dll_pkg::KIND_ERROR, '0, '0,
                                       dll_pkg::ERR_CHAR, 1'b0);
        end
    end

    // candidate accumulator values and their overflow conditions
    logic [VW+3:0] mul10;
    logic          ovf10, ovf2, ovf8, ovf16;
    logic [VW-1:0] acc2, acc8, acc16;

    assign mul10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (VW+4)'(d_val);
    assign ovf10 = |mul10[VW+3:VW];
    assign ovf2  = r_acc[VW-1];
    assign ovf8  = |r_acc[VW-1:VW-3];
    assign ovf16 = |r_acc[VW-1:VW-4];
    assign acc2  = {r_acc[VW-2:0], d_val[0]};
    assign acc8  = {r_acc[VW-4:0], d_val[2:0]};
    assign acc16 = {r_acc[VW-5:0], d_val[3:0]};

    // mode step
    logic             emit_a;
    dll_pkg::t_result res_a;
    logic             go_normal;
    logic             acc_en;
    logic             acc_over;
    logic [VW-1:0]    acc_next;
    logic             is_usc;

    assign is_usc = is_ascii && ch == CH_USCORE;

    always_comb begin
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_cnt     = r_cnt;
        n_halt    = r_halt;
        emit_a    = 1'b0;
        res_a     = dll_pkg::mk_res(dll_pkg::KIND_VALUE, r_acc, '0, 1'b0, r_ovf);
        go_normal = 1'b0;
        acc_en    = 1'b0;
        acc_over  = 1'b0;
        acc_next  = r_acc;
        if (i_valid && i_eoi) begin
            n_mode = M_NORMAL;
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_cnt  = '0;
            n_halt = 1'b0;
        end else if (i_valid && !r_halt) begin
            case (r_mode)
                M_COMMENT: begin
                    if (is_ascii && ch == CH_NL) begin
                        n_mode = M_NORMAL;
                    end
                end
                M_IDENT: begin
                    if (!(is_letter || is_digit || is_usc)) begin
                        go_normal = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (is_ascii && ch == CH_LO_B) begin
                        n_mode = M_BIN;
                    end else if (is_ascii && ch == CH_LO_O) begin
                        n_mode = M_OCT;
                    end else if (is_ascii && ch == CH_LO_X) begin
                        n_mode = M_HEX;
                    end else if (is_ascii && ch == CH_DOT) begin
                        n_mode = M_FRAC;
                    end else if (is_digit) begin
                        // accumulator is zero here, so the value is the digit
                        n_mode = M_DEC;
                        n_acc  = VW'(d_val);
                    end else if (is_usc) begin
                        n_mode = M_DEC;
                    end else begin
                        emit_a    = 1'b1;
                        go_normal = 1'b1;
                    end
                end
                M_BIN: begin
                    if (d_val < 6'd2) begin
                        acc_en   = 1'b1;
                        acc_over = ovf2;
                        acc_next = acc2;
                    end else if (!is_usc) begin
                        emit_a    = 1'b1;
                        go_normal = 1'b1;
                    end
                end
                M_OCT: begin
                    if (d_val < 6'd8) begin
                        acc_en   = 1'b1;
                        acc_over = ovf8;
                        acc_next = acc8;
                    end else if (!is_usc) begin
                        emit_a    = 1'b1;
                        go_normal = 1'b1;
                    end
                end
                M_HEX: begin
                    if (d_val < 6'd16) begin
                        acc_en   = 1'b1;
                        acc_over = ovf16;
                        acc_next = acc16;
                    end else if (!is_usc) begin
                        emit_a    = 1'b1;
                        go_normal = 1'b1;
                    end
                end
                M_DEC: begin
                    if (is_digit) begin
                        acc_en   = 1'b1;
                        acc_over = ovf10;
                        acc_next = mul10[VW-1:0];
                    end else if (!is_usc) begin
                        emit_a    = 1'b1;
                        go_normal = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit) begin
                        acc_en   = 1'b1;
                        acc_over = ovf10;
                        acc_next = mul10[VW-1:0];
                        if (r_cnt != '1) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else if (!is_usc) begin
                        emit_a    = 1'b1;
                        res_a     = dll_pkg::mk_res(dll_pkg::KIND_FRAC, r_acc, r_cnt,
                                                    1'b0, r_ovf);
                        go_normal = 1'b1;
                    end
                end
                M_STRING: begin
                    if (is_ascii && ch == CH_QUOTE) begin
                        n_mode = M_NORMAL;
                    end else if (is_ascii && ch == CH_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end else begin
                        emit_a = 1'b1;
                        res_a  = dll_pkg::mk_res(dll_pkg::KIND_VALUE, VW'(i_rune), '0,
                                                 1'b0, 1'b0);
                    end
                end
                M_ESCAPE: begin
                    emit_a = 1'b1;
                    if (esc_ok) begin
                        n_mode = M_STRING;
                        res_a  = dll_pkg::mk_res(dll_pkg::KIND_VALUE, VW'(esc_code), '0,
                                                 1'b0, 1'b0);
                    end else begin
                        n_mode = M_NORMAL;
                        n_halt = 1'b1;
                        res_a  = dll_pkg::mk_res(dll_pkg::KIND_ERROR, '0, '0,
                                                 dll_pkg::ERR_ESCAPE, 1'b0);
                    end
                end
                default: begin
                    go_normal = 1'b1;
                end
            endcase

            // saturating accumulate, frozen once overflow was seen
            if (acc_en && !r_ovf) begin
                if (acc_over) begin
                    n_ovf = 1'b1;
                    n_acc = '1;
                end else begin
                    n_acc = acc_next;
                end
            end

            // rune is taken again in normal mode
            if (go_normal) begin
                n_mode = nrm_mode;
                n_acc  = nrm_acc;
                n_ovf  = 1'b0;
                n_cnt  = '0;
                n_halt = nrm_halt;
            end
        end
    end

    // assemble the result pair
    logic emit_b;

    assign emit_b = go_normal && nrm_emit;

    always_comb begin
        o_pair.num       = {1'b0, emit_a} + {1'b0, emit_b};
        o_pair.res0      = emit_a ? res_a : nrm_res;
        o_pair.res0.last = !(emit_a && emit_b);
        o_pair.res1      = nrm_res;
        o_pair.res1.last = 1'b1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
            r_halt <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_cnt  <= n_cnt;
            r_halt <= n_halt;
        end
    end

endmodule

FILE: rtl/dll_resq.sv
// result queue: takes up to two result words a cycle, gives one a cycle when popped
// decouples the rune side from the result side
// depends on dll_pkg
module dll_resq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dll_pkg::t_pair                 i_pair,
    input  logic                           i_pop,
    output logic                           o_nonempty,
    output logic                           o_room2,
    output dll_pkg::t_result               o_head
);

    localparam int PW = dll_pkg::RQ_PTR_W;
    localparam int CW = dll_pkg::RQ_CNT_W;

    dll_pkg::t_result r_mem [dll_pkg::RQ_DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]    wp1;

    assign wp1        = r_wp + 1'b1;
    assign o_nonempty = (r_cnt != '0);
    assign o_room2    = (r_cnt <= CW'(dll_pkg::RQ_DEPTH - 2));
    assign o_head     = r_mem[r_rp];

    // pointer and fill count
    always_comb begin
        n_wp  = r_wp + PW'(i_pair.num);
        n_rp  = r_rp + PW'(i_pop);
        n_cnt = r_cnt + CW'(i_pair.num) - CW'(i_pop);
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_pair.num != 2'd0) begin
            r_mem[r_wp] <= i_pair.res0;
        end
        if (i_pair.num == 2'd2) begin
            r_mem[wp1] <= i_pair.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: rtl/data_literal_lexer.sv
// top level of the data literal lexer: stream ports, lexer core, result queue
// depends on dll_pkg, dll_core and dll_resq
//
// One code point enters per word on the slave side and every rune is decoded
// in the cycle it is accepted; its results are queued for the master side.
// Runes go in at one per cycle as long as the result side keeps
// up; a rune that ends a literal and is itself a brace or an invalid
// character gives two words, which leave one per cycle. The four-entry
// result queue sets the rate: s_axis_tready is high while at least two
// entries are free, so a stalled master side stops input with three or four
// words queued. An end marker (tlast) clears the core state and gives no result.
module data_literal_lexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // rune [20:0], zero [23:21]
    input  logic        i_s_axis_tlast,  // end_of_input
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,  // value [63:0], fraction_digits [71:64],
                                         // error_code [72], saturated [73], zero [79:74]
    output logic [2:0]  o_m_axis_tuser,  // kind [2:0]
    output logic        o_m_axis_tlast   // last_of_run
);

    logic             s_accept;
    logic             q_room2;
    dll_pkg::t_pair   pair;
    dll_pkg::t_result head;

    assign o_s_axis_tready = q_room2;
    assign s_accept        = i_s_axis_tvalid && q_room2;

    // lexer core
    dll_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_accept),
        .i_rune  (i_s_axis_tdata[dll_pkg::RUNE_W-1:0]),
        .i_eoi   (i_s_axis_tlast),
        .o_pair  (pair)
    );

    // result queue
    dll_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair     (pair),
        .i_pop      (o_m_axis_tvalid && i_m_axis_tready),
        .o_nonempty (o_m_axis_tvalid),
        .o_room2    (q_room2),
        .o_head     (head)
    );

    // master side word
    assign o_m_axis_tdata = {6'b0, head.sat, head.err, head.frac, head.value};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

endmodule
